/* hw/rtl/lkvt_pkg.sv */
// Package for the linear key/value table: command and result types,
// status and kind codes, and parameter defaults. Depends on nothing.
`default_nettype none

package lkvt_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic KIND_PUT    = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_INSERTED  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [31:0] key;
        logic [31:0] write_value;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] read_value;
    } t_out;

    typedef struct packed {
        logic key_we;
        logic val_we;
    } t_mem_we;

endpackage

`default_nettype wire

/* hw/rtl/lkvt_store.sv */
// Key and value memories of the linear key/value table, one write port and
// one registered read port each. Depends on lkvt_pkg.
`default_nettype none

module lkvt_store #(
    parameter int ENTRIES    = lkvt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvt_pkg::VALUE_BITS_DEF,
    parameter int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                   i_clk,
    input  lkvt_pkg::t_mem_we      i_we,
    input  logic [IDX_W-1:0]       i_waddr,
    input  logic [KEY_BITS-1:0]    i_wkey,
    input  logic [VALUE_BITS-1:0]  i_wval,
    input  logic [IDX_W-1:0]       i_kaddr,
    input  logic [IDX_W-1:0]       i_vaddr,
    output logic [KEY_BITS-1:0]    o_kdata,
    output logic [VALUE_BITS-1:0]  o_vdata
);
    import lkvt_pkg::*;

    logic [KEY_BITS-1:0]   r_key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] r_val_mem [ENTRIES];
    logic [KEY_BITS-1:0]   r_kdata;
    logic [VALUE_BITS-1:0] r_vdata;

    always_ff @(posedge i_clk) begin
        if (i_we.key_we) begin
            r_key_mem[i_waddr] <= i_wkey;
        end
        r_kdata <= r_key_mem[i_kaddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.val_we) begin
            r_val_mem[i_waddr] <= i_wval;
        end
        r_vdata <= r_val_mem[i_vaddr];
    end

    assign o_kdata = r_kdata;
    assign o_vdata = r_vdata;

endmodule

`default_nettype wire

/* hw/rtl/linear_key_value_table.sv */
// Top level of the linear key/value table: command sequencer, fill count
// and result register. Depends on lkvt_pkg and lkvt_store.
//
// A command is taken when start is high and busy is low. One result follows
// for every command, shown for a single cycle with o_valid and not held off
// by the receiver. The keys are compared one per cycle from the key memory's
// single read port. A command that misses compares every filled slot before
// its result, and compares none on an empty table. A command that hits in
// slot k ends the scan there, and a lookup then reads that slot's value from
// the value memory. A new command may be given in the cycle the result is
// shown.
`default_nettype none

module linear_key_value_table #(
    parameter int ENTRIES    = lkvt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvt_pkg::VALUE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  lkvt_pkg::t_in  i_cmd,
    output logic           busy,
    output logic           o_valid,
    output lkvt_pkg::t_out o_result
);
    import lkvt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_VAL  = 2'd2;

    logic [1:0]            r_state;
    logic [CNT_W-1:0]      r_fill;
    logic                  r_issue;
    logic                  r_kvld;
    logic                  r_valid;
    logic                  r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_wval;
    logic [IDX_W-1:0]      r_addr;
    logic [IDX_W-1:0]      r_kidx;
    t_out                  r_result;

    logic [KEY_BITS-1:0]   w_kdata;
    logic [VALUE_BITS-1:0] w_vdata;
    logic [CNT_W-1:0]      w_last;
    logic                  w_at_last;
    logic                  w_hit;
    logic                  w_miss;
    logic                  w_room;
    logic                  w_put;
    t_mem_we               w_we;
    logic [IDX_W-1:0]      w_waddr;

    assign w_last    = r_fill - CNT_W'(1);
    assign w_at_last = (CNT_W'(r_addr) == w_last);
    assign w_hit     = (r_state == S_SCAN) && r_kvld && (w_kdata == r_key);
    assign w_miss    = (r_state == S_SCAN) && !w_hit && !r_issue && !r_kvld;
    assign w_room    = (r_fill < CNT_W'(ENTRIES));
    assign w_put     = (r_kind == KIND_PUT);

    assign w_we.key_we = w_miss && w_put && w_room;
    assign w_we.val_we = w_put && (w_hit || (w_miss && w_room));
    assign w_waddr     = w_hit ? r_kidx : IDX_W'(r_fill);

    lkvt_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wkey  (r_key),
        .i_wval  (r_wval),
        .i_kaddr (r_addr),
        .i_vaddr (r_kidx),
        .o_kdata (w_kdata),
        .o_vdata (w_vdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_issue <= 1'b0;
            r_kvld  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_kvld <= 1'b0;
                    if (start) begin
                        r_state <= S_SCAN;
                        r_issue <= (r_fill != '0);
                    end
                end
                S_SCAN: begin
                    r_kvld <= r_issue && !w_hit;
                    if (r_issue && w_at_last) begin
                        r_issue <= 1'b0;
                    end
                    if (w_hit) begin
                        r_issue <= 1'b0;
                        if (r_kind == KIND_LOOKUP) begin
                            r_state <= S_VAL;
                        end else begin
                            r_state <= S_IDLE;
                            r_valid <= 1'b1;
                        end
                    end else if (w_miss) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                        if (w_put && w_room) begin
                            r_fill <= r_fill + CNT_W'(1);
                        end
                    end
                end
                S_VAL: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_kind <= i_cmd.kind;
            r_key  <= KEY_BITS'(i_cmd.key);
            r_wval <= VALUE_BITS'(i_cmd.write_value);
            r_addr <= '0;
        end else if (r_state == S_SCAN && r_issue && !w_at_last) begin
            r_addr <= r_addr + IDX_W'(1);
        end
        if (r_state == S_SCAN && !w_hit) begin
            r_kidx <= r_addr;
        end
        if (w_hit && w_put) begin
            r_result <= '{status: ST_FOUND, slot: 4'(r_kidx), read_value: '0};
        end else if (w_miss) begin
            if (!w_put) begin
                r_result <= '{status: ST_NOT_FOUND, slot: '0, read_value: '0};
            end else if (w_room) begin
                r_result <= '{status: ST_INSERTED, slot: 4'(r_fill), read_value: '0};
            end else begin
                r_result <= '{status: ST_FULL, slot: '0, read_value: '0};
            end
        end else if (r_state == S_VAL) begin
            r_result <= '{status: ST_FOUND, slot: 4'(r_kidx), read_value: 32'(w_vdata)};
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_one_cycle_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_take_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(ENTRIES))
        else $error("fill count beyond capacity");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_INSERTED) |-> (r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("insertion reported without fill count advance");

endmodule

`default_nettype wire

/* tb/tb_linear_key_value_table.sv */
// Self-checking testbench for the linear key/value table: directed and random put and
// lookup commands, each result checked against a predicted copy of the table.
// Depends on lkvt_pkg and linear_key_value_table.
`default_nettype none

module tb_linear_key_value_table;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvt_pkg::*;

    localparam int SLOTS         = ENTRIES_DEF;
    localparam int RANDOM_ITEMS  = 1080;
    localparam int SETTLE_CYCLES = 25;
    localparam int CYCLE_LIMIT   = 300000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_cmd   = '0;
    logic busy;
    logic o_valid;
    t_out o_result;

    logic [31:0] model_keys   [SLOTS];
    logic [31:0] model_values [SLOTS];
    int          model_fill   = 0;
    t_out        expected_results [$];
    int          error_count  = 0;
    int          cycle_count  = 0;
    bit          send_idle    = 1'b1;

    linear_key_value_table DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic t_out predict_table_result(input t_in cmd);
        t_out res;
        int   hit;
        res = '0;
        hit = -1;
        for (int s = 0; s < model_fill; s++) begin
            if (hit < 0 && model_keys[s] == cmd.key) begin
                hit = s;
            end
        end
        if (cmd.kind == KIND_LOOKUP) begin
            if (hit >= 0) begin
                res.status     = ST_FOUND;
                res.slot       = hit[3:0];
                res.read_value = model_values[hit];
            end else begin
                res.status = ST_NOT_FOUND;
            end
        end else if (hit >= 0) begin
            model_values[hit] = cmd.write_value;
            res.status        = ST_FOUND;
            res.slot          = hit[3:0];
        end else if (model_fill < SLOTS) begin
            model_keys[model_fill]   = cmd.key;
            model_values[model_fill] = cmd.write_value;
            res.status               = ST_INSERTED;
            res.slot                 = model_fill[3:0];
            model_fill++;
        end else begin
            res.status = ST_FULL;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", {26'd0, o_result.status, o_result.slot},
                                32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", 32'(o_result.status), 32'(want.status));
                if (o_result.slot !== want.slot)
                    report_mismatch("slot", 32'(o_result.slot), 32'(want.slot));
                if (o_result.read_value !== want.read_value)
                    report_mismatch("read_value", o_result.read_value, want.read_value);
            end
        end
    end

    function automatic t_in make_cmd(input logic kind, input logic [31:0] key,
                                     input logic [31:0] value);
        t_in cmd;
        cmd.kind        = kind;
        cmd.key         = key;
        cmd.write_value = value;
        return cmd;
    endfunction

    function automatic bit key_is_stored(input logic [31:0] key);
        for (int s = 0; s < model_fill; s++) begin
            if (model_keys[s] == key) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] fresh_key();
        logic [31:0] key;
        do key = $urandom(); while (key_is_stored(key));
        return key;
    endfunction

    // Start stays high across back-to-back commands; it is lowered for a gap and by wait_for_drain.
    task automatic send_cmd(input t_in cmd);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_results.push_back(predict_table_result(cmd));
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic test_empty_table();
        send_cmd(make_cmd(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000));
        send_cmd(make_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_insert_extremes();
        send_cmd(make_cmd(KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF));
        send_cmd(make_cmd(KIND_PUT, 32'hFFFF_FFFF, 32'h0000_0000));
        send_cmd(make_cmd(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000));
        send_cmd(make_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_update_existing();
        send_cmd(make_cmd(KIND_PUT, 32'h0000_0000, 32'h0000_0000));
        send_cmd(make_cmd(KIND_LOOKUP, 32'h0000_0000, 32'h1234_5678));
        send_cmd(make_cmd(KIND_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A));
        send_cmd(make_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000));
        send_cmd(make_cmd(KIND_LOOKUP, 32'h8000_0001, 32'h0000_0000));
    endtask

    function automatic logic [31:0] pick_key();
        if (model_fill != 0 && $urandom_range(0, 1) == 1)
            return model_keys[$urandom_range(0, model_fill - 1)];
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_random_traffic();
        t_in cmd;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) send_idle = ($urandom_range(0, 3) != 0);
            if (n == RANDOM_ITEMS / 2) wait_for_drain();
            cmd = make_cmd($urandom_range(0, 1) ? KIND_LOOKUP : KIND_PUT, pick_key(),
                           $urandom());
            send_cmd(cmd);
        end
    endtask

    task automatic test_full_table();
        logic [31:0] spare_key;
        send_idle = 1'b1;
        while (model_fill < SLOTS) begin
            send_cmd(make_cmd(KIND_PUT, fresh_key(), $urandom()));
        end
        spare_key = fresh_key();
        send_cmd(make_cmd(KIND_PUT, spare_key, $urandom()));
        send_cmd(make_cmd(KIND_LOOKUP, spare_key, $urandom()));
        send_cmd(make_cmd(KIND_PUT, model_keys[SLOTS - 1], $urandom()));
        send_cmd(make_cmd(KIND_LOOKUP, model_keys[SLOTS - 1], $urandom()));
        send_cmd(make_cmd(KIND_LOOKUP, model_keys[0], $urandom()));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_insert_extremes();
        test_update_existing();
        test_random_traffic();
        test_full_table();
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* linear_key_value_table.f */
hw/rtl/lkvt_pkg.sv
hw/rtl/lkvt_store.sv
hw/rtl/linear_key_value_table.sv
tb/tb_linear_key_value_table.sv
